### hw/rtl/plsl_pkg.sv
package plsl_pkg;

  // list capacity and derived widths
  localparam int LIST_DEPTH = 1024;
  localparam int POS_W      = 10;
  localparam int KEY_W      = 32;
  localparam int PRICE_W    = 24;
  localparam int QTY_W      = 16;
  localparam int CNT_W      = 11;
  localparam int SUM_W      = 34;
  localparam int CNT_IW     = $clog2(LIST_DEPTH + 1);
  localparam int CMP_W      = (CNT_IW > POS_W) ? CNT_IW : POS_W;

  // read gather tree: groups of cells, one registered level
  localparam int GROUP      = 32;
  localparam int GRP_BITS   = $clog2(GROUP);
  localparam int NUM_GROUPS = (LIST_DEPTH + GROUP - 1) / GROUP;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } entry_t;

  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic [CMP_W-1:0] pos;
    entry_t           new_entry;
  } cell_ctl_t;

endpackage

### hw/rtl/plsl_cell.sv
module plsl_cell (
  input  logic                 clk,
  input  plsl_pkg::cell_ctl_t  ctl,
  input  logic [plsl_pkg::CMP_W-1:0] idx,
  input  plsl_pkg::entry_t     left_entry,
  input  plsl_pkg::entry_t     right_entry,
  output plsl_pkg::entry_t     entry
);
  import plsl_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift_up) begin
      // open a slot at pos: later cells take their left neighbor
      if (idx > ctl.pos) begin
        entry_nxt = left_entry;
      end else if (idx == ctl.pos) begin
        entry_nxt = ctl.new_entry;
      end
    end else if (ctl.shift_down) begin
      // close the slot at pos: cells from pos on take their right neighbor
      if (idx >= ctl.pos) begin
        entry_nxt = right_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

### hw/rtl/plsl_read.sv
module plsl_read (
  input  logic                        clk,
  input  plsl_pkg::entry_t            cells [plsl_pkg::LIST_DEPTH],
  input  logic [plsl_pkg::POS_W-1:0]  pos,
  output plsl_pkg::entry_t            rd_entry
);
  import plsl_pkg::*;

  entry_t group_r   [NUM_GROUPS];
  entry_t group_nxt [NUM_GROUPS];

  logic [GRP_BITS-1:0]       offset;
  logic [POS_W-GRP_BITS-1:0] grp_sel;

  assign offset  = pos[GRP_BITS-1:0];
  assign grp_sel = pos[POS_W-1:GRP_BITS];

  // first level: pick the cell at the offset within each group
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_nxt[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if ((g * GROUP + j < LIST_DEPTH) && (int'(offset) == j)) begin
          group_nxt[g] = cells[g * GROUP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_r[g] <= group_nxt[g];
    end
  end

  // second level: pick the group
  always_comb begin
    rd_entry = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (int'(grp_sel) == g) begin
        rd_entry = group_r[g];
      end
    end
  end

endmodule

### hw/rtl/positional_array_list_top.sv
// Positional array list: an ordered list of records (key, unit price,
// quantity) held in a chain of cells, one record per cell.
// Input channel (in_valid/in_ready): one operation per transaction -
// insert at position, remove at position, read entry, or clear.
// Output channel (out_valid/out_ready): one result per transaction with
// success flag, count after the operation, the read record (zero unless a
// successful read) and the running total of unit prices.
// Sequence: an operation goes through accept, gather through the two-level
// read tree (groups of 32 cells, registered, then a group select), and apply.
// The read tree is why gather exists: remove needs the departing price
// and read needs the entry before the chain shifts. A new operation is only
// accepted once the previous one has been applied.
// Insert and remove shift every cell from the position on at once, whatever the position.
// Reset: count and total go to zero; cell contents are left undefined and
// only ever reached after an insert wrote them.
// Stall: a result waits in the output register; the next operation may be
// accepted and gathered meanwhile, and holds in apply until the output
// register frees up.
module positional_array_list_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [plsl_pkg::POS_W-1:0]    in_position,
  input  logic [plsl_pkg::KEY_W-1:0]    in_item_key,
  input  logic [plsl_pkg::PRICE_W-1:0]  in_unit_price,
  input  logic [plsl_pkg::QTY_W-1:0]    in_quantity,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ok,
  output logic [plsl_pkg::CNT_W-1:0]    out_entry_count,
  output logic [plsl_pkg::KEY_W-1:0]    out_read_key,
  output logic [plsl_pkg::PRICE_W-1:0]  out_read_price,
  output logic [plsl_pkg::QTY_W-1:0]    out_read_quantity,
  output logic [plsl_pkg::SUM_W-1:0]    out_total_price
);
  import plsl_pkg::*;

  state_t state_r, state_nxt;

  // captured transaction
  op_t              op_r;
  logic [POS_W-1:0] pos_r;
  entry_t           new_r;

  // list bookkeeping
  logic [CNT_IW-1:0] count_r, count_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              ok_r;
  logic [CNT_W-1:0]  cnt_out_r;
  entry_t            rd_out_r;
  logic [SUM_W-1:0]  sum_out_r;

  // chain
  entry_t    cells [LIST_DEPTH];
  cell_ctl_t ctl;
  entry_t    rd_entry;

  logic             advance;
  logic             apply_go;
  logic [CMP_W-1:0] pos_ext, cnt_ext, ins_pos;
  logic             ok_c;
  entry_t           rd_c;

  assign advance = !out_valid_r || out_ready;
  assign pos_ext = CMP_W'(pos_r);
  assign cnt_ext = CMP_W'(count_r);
  // a position past the count appends
  assign ins_pos = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_GATHER;
      ST_GATHER: state_nxt = ST_APPLY;
      ST_APPLY:  if (advance) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    apply_go = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_GATHER: ;
      ST_APPLY:  apply_go = advance;
      default:   ;
    endcase
  end

  // work out the result and the new bookkeeping
  always_comb begin
    ok_c      = 1'b0;
    rd_c      = '0;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    ctl       = '0;
    ctl.new_entry = new_r;
    case (op_r)
      OP_INSERT: begin
        if (count_r < CNT_IW'(LIST_DEPTH)) begin
          ok_c          = 1'b1;
          count_nxt     = count_r + 1'b1;
          sum_nxt       = sum_r + SUM_W'(new_r.price);
          ctl.shift_up  = apply_go;
          ctl.pos       = ins_pos;
        end
      end
      OP_REMOVE: begin
        if (pos_ext < cnt_ext) begin
          ok_c           = 1'b1;
          count_nxt      = count_r - 1'b1;
          sum_nxt        = sum_r - SUM_W'(rd_entry.price);
          ctl.shift_down = apply_go;
          ctl.pos        = pos_ext;
        end
      end
      OP_READ: begin
        if (pos_ext < cnt_ext) begin
          ok_c = 1'b1;
          rd_c = rd_entry;
        end
      end
      default: begin
        ok_c      = 1'b1;
        count_nxt = '0;
        sum_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (apply_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (apply_go) begin
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
      end
    end
  end

  // payload: hold the transaction, load the result on apply
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r      <= op_t'(in_op);
      pos_r     <= in_position;
      new_r     <= '{key: in_item_key, price: in_unit_price, qty: in_quantity};
    end
    if (apply_go) begin
      ok_r      <= ok_c;
      cnt_out_r <= CNT_W'(count_nxt);
      rd_out_r  <= rd_c;
      sum_out_r <= sum_nxt;
    end
  end

  // chain of cells; ends tie to harmless neighbors
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    if (i == 0) begin : g_first
      assign left_e = new_r;
    end else begin : g_mid_l
      assign left_e = cells[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_e = cells[i];
    end else begin : g_mid_r
      assign right_e = cells[i+1];
    end
    plsl_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .idx         (CMP_W'(i)),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (cells[i])
    );
  end

  plsl_read u_read (
    .clk      (clk),
    .cells    (cells),
    .pos      (pos_r),
    .rd_entry (rd_entry)
  );

  assign out_valid         = out_valid_r;
  assign out_ok            = ok_r;
  assign out_entry_count   = cnt_out_r;
  assign out_read_key      = rd_out_r.key;
  assign out_read_price    = rd_out_r.price;
  assign out_read_quantity = rd_out_r.qty;
  assign out_total_price   = sum_out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_IW'(LIST_DEPTH))
    else $error("entry count beyond capacity");

  a_accept_gathers: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_GATHER))
    else $error("accepted transaction did not enter gather");

  a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_APPLY))
    else $error("result raised outside apply");

  a_no_shift_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.shift_up && ctl.shift_down))
    else $error("chain told to shift both ways");

  a_failed_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !ok_r) |-> (rd_out_r == '0))
    else $error("failed operation returned record data");

endmodule
